// ===== design/lpd_pkg.sv =====
// shared types and constants for the length-prefixed deframer
package lpd_pkg;

    localparam logic [31:0] MAGIC_WORD_RESET     = 32'h6F61696D;
    localparam logic [12:0] HANDSHAKE_LEN_RESET  = 13'd1024;
    localparam logic [15:0] MAX_MSG_LEN_RESET    = 16'd65535;
    localparam logic [12:0] HANDSHAKE_LEN_MIN    = 13'd4;
    localparam logic [12:0] HANDSHAKE_LEN_MAX    = 13'd4096;
    localparam logic [2:0]  HEADER_BYTES         = 3'd4;
    localparam logic [31:0] MIN_MSG_LEN          = 32'd4;

    typedef enum logic [1:0] {
        CFG_MAGIC_WORD    = 2'd0,
        CFG_HANDSHAKE_LEN = 2'd1,
        CFG_MAX_MSG_LEN   = 2'd2
    } lpd_cfg_addr_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_BADLEN = 2'd3
    } lpd_kind_t;

    typedef enum logic [1:0] {
        PH_HANDSHAKE = 2'd0,
        PH_STREAM    = 2'd1,
        PH_CLOSED    = 2'd2
    } lpd_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       connection_start;
    } lpd_in_t;

    typedef struct packed {
        lpd_kind_t   kind;
        logic [7:0]  out_byte;
        logic        message_last;
        logic [15:0] message_length;
    } lpd_out_t;

    typedef struct packed {
        logic     emit;
        lpd_out_t item;
    } lpd_result_t;

endpackage

// ===== design/lpd_parser.sv =====
// connection state, configuration registers and per-byte framing decisions
module lpd_parser import lpd_pkg::*; #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_addr,
    input  logic [31:0]         cfg_wdata,
    input  logic                in_accept,
    input  lpd_in_t             in_data,
    output lpd_result_t         result
);

    localparam logic [32:0] CAP_LEN = (33'd1 << LENGTH_WIDTH) - 33'd1;

    logic [31:0]             magic_word_reg;
    logic [12:0]             handshake_len_reg;
    logic [15:0]             max_msg_len_reg;

    lpd_phase_t              phase_reg, phase_next, phase_cur;
    logic [11:0]             hs_count_reg, hs_count_next, hs_count_cur;
    logic                    magic_ok_reg, magic_ok_next, magic_ok_cur;
    logic [23:0]             shift_reg, shift_next;
    logic [2:0]              hdr_count_reg, hdr_count_next, hdr_count_cur;
    logic [LENGTH_WIDTH-1:0] bytes_left_reg, bytes_left_next, bytes_left_dec;
    logic [LENGTH_WIDTH-1:0] msg_len_reg, msg_len_next;

    logic [12:0]             hs_len_eff;
    logic [7:0]              want_byte;
    logic                    magic_ok_upd;
    logic [31:0]             len_word;
    logic [31:0]             msg_len_ext;
    logic                    len_bad;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_word_reg    <= MAGIC_WORD_RESET;
            handshake_len_reg <= HANDSHAKE_LEN_RESET;
            max_msg_len_reg   <= MAX_MSG_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_MAGIC_WORD:    magic_word_reg    <= cfg_wdata;
                CFG_HANDSHAKE_LEN: handshake_len_reg <= cfg_wdata[12:0];
                CFG_MAX_MSG_LEN:   max_msg_len_reg   <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // a connection start clears the state before the byte is taken
    assign phase_cur     = in_data.connection_start ? PH_HANDSHAKE : phase_reg;
    assign hs_count_cur  = in_data.connection_start ? 12'd0 : hs_count_reg;
    assign magic_ok_cur  = in_data.connection_start ? 1'b1 : magic_ok_reg;
    assign hdr_count_cur = in_data.connection_start ? 3'd0 : hdr_count_reg;

    assign hs_len_eff = (handshake_len_reg < HANDSHAKE_LEN_MIN) ? HANDSHAKE_LEN_MIN :
                        (handshake_len_reg > HANDSHAKE_LEN_MAX) ? HANDSHAKE_LEN_MAX :
                        handshake_len_reg;

    assign want_byte    = magic_word_reg[8*hs_count_cur[1:0] +: 8];
    assign magic_ok_upd = magic_ok_cur &&
                          ((hs_count_cur >= 12'd4) || (want_byte == in_data.data_byte));

    assign len_word    = {in_data.data_byte, shift_reg};
    assign len_bad     = (len_word < MIN_MSG_LEN) || (len_word > {16'd0, max_msg_len_reg}) ||
                         ({1'b0, len_word} > CAP_LEN);
    assign msg_len_ext = 32'(msg_len_reg);

    assign bytes_left_dec = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;

    always_comb begin
        phase_next      = phase_reg;
        hs_count_next   = hs_count_reg;
        magic_ok_next   = magic_ok_reg;
        shift_next      = shift_reg;
        hdr_count_next  = hdr_count_reg;
        bytes_left_next = bytes_left_reg;
        msg_len_next    = msg_len_reg;
        result          = '0;
        result.item.kind = KIND_DATA;
        if (in_accept) begin
            phase_next     = phase_cur;
            hs_count_next  = hs_count_cur;
            magic_ok_next  = magic_ok_cur;
            hdr_count_next = hdr_count_cur;
            unique case (phase_cur)
                PH_HANDSHAKE: begin
                    magic_ok_next = magic_ok_upd;
                    if ({1'b0, hs_count_cur} + 13'd1 >= hs_len_eff) begin
                        hs_count_next    = 12'd0;
                        result.emit      = 1'b1;
                        phase_next       = magic_ok_upd ? PH_STREAM : PH_CLOSED;
                        result.item.kind = magic_ok_upd ? KIND_ACCEPT : KIND_REJECT;
                    end else begin
                        hs_count_next = hs_count_cur + 12'd1;
                    end
                end
                PH_STREAM: begin
                    result.emit          = 1'b1;
                    result.item.out_byte = in_data.data_byte;
                    if (hdr_count_cur < HEADER_BYTES - 3'd1) begin
                        unique case (hdr_count_cur[1:0])
                            2'd0:    shift_next[7:0]   = in_data.data_byte;
                            2'd1:    shift_next[15:8]  = in_data.data_byte;
                            default: shift_next[23:16] = in_data.data_byte;
                        endcase
                        hdr_count_next = hdr_count_cur + 3'd1;
                    end else if (hdr_count_cur == HEADER_BYTES - 3'd1) begin
                        if (len_bad) begin
                            phase_next           = PH_CLOSED;
                            hdr_count_next       = 3'd0;
                            result.item.kind     = KIND_BADLEN;
                            result.item.out_byte = 8'd0;
                        end else begin
                            msg_len_next               = len_word[LENGTH_WIDTH-1:0];
                            bytes_left_next            = LENGTH_WIDTH'(len_word - MIN_MSG_LEN);
                            result.item.message_length = len_word[15:0];
                            if (len_word == MIN_MSG_LEN) begin
                                hdr_count_next           = 3'd0;
                                result.item.message_last = 1'b1;
                            end else begin
                                hdr_count_next = HEADER_BYTES;
                            end
                        end
                    end else begin
                        // message body
                        bytes_left_next            = bytes_left_dec;
                        result.item.message_length = msg_len_ext[15:0];
                        if (bytes_left_dec == '0) begin
                            hdr_count_next           = 3'd0;
                            result.item.message_last = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HANDSHAKE;
            hs_count_reg   <= 12'd0;
            magic_ok_reg   <= 1'b1;
            hdr_count_reg  <= 3'd0;
            bytes_left_reg <= '0;
        end else begin
            phase_reg      <= phase_next;
            hs_count_reg   <= hs_count_next;
            magic_ok_reg   <= magic_ok_next;
            hdr_count_reg  <= hdr_count_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg   <= shift_next;
        msg_len_reg <= msg_len_next;
    end

    a_hdr_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_count_reg <= HEADER_BYTES)
        else $error("header count out of range");

    a_body_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        (hdr_count_reg == HEADER_BYTES) |-> (bytes_left_reg != '0))
        else $error("body state with no bytes left");

    a_hs_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_HANDSHAKE) |-> (hs_count_reg == 12'd0))
        else $error("handshake count left over after verdict");

endmodule

// ===== design/length_prefixed_deframer_unit.sv =====
// length-prefixed deframer: top level with output register
//
// s_ channel carries one received byte per transaction plus a connection
// start flag that clears the connection state before that byte is taken.
// The first handshake_length bytes of a connection form a handshake; its
// first four bytes are compared with magic_word and one verdict
// transaction (accepted or rejected) is sent on the last handshake byte.
// After acceptance each message byte, the 4-byte little-endian length
// header included, goes out on the m_ channel, the final byte flagged by
// message_last. A bad length gives one bad-length transaction and closes
// the stream until the next connection start. Configuration is a plain
// write port, one register per index 0 to 2, to be written only while
// the block is idle (not enforced). Throughput is one byte per cycle
// unless the receiver stalls; the single output register puts a result
// on m_valid in the cycle after its input. A held result blocks s_ready
// until it is taken; accepting resumes in the same cycle m_ready returns.
// Reset empties the output register and restores configuration defaults.
module length_prefixed_deframer_unit import lpd_pkg::*; #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  lpd_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output lpd_out_t    m_data
);

    logic        m_valid_reg;
    lpd_out_t    m_data_reg;
    logic        in_accept;
    lpd_result_t result;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    lpd_parser #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_data   (s_data),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= result.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && result.emit) begin
            m_data_reg <= result.item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_last_is_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.message_last) |-> (m_data.kind == KIND_DATA))
        else $error("last flag on a non-data transaction");

    a_status_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.kind != KIND_DATA)) |->
        ((m_data.out_byte == 8'd0) && (m_data.message_length == 16'd0)))
        else $error("status transaction carries payload");

    a_empty_after_reset: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_valid)
        else $error("output valid right after reset");

endmodule

// ===== test/tb_length_prefixed_deframer_unit.sv =====
// self-checking testbench for length_prefixed_deframer_unit
`timescale 1ns / 1ps

module tb_length_prefixed_deframer_unit;
    import lpd_pkg::*;

    localparam int LENGTH_WIDTH = 16;
    localparam logic [32:0] LEN_CAP = (33'd1 << LENGTH_WIDTH) - 33'd1;
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int WHOLE = -1;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 8;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    lpd_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    lpd_out_t    m_data;

    // configuration as the deframer should currently hold it
    logic [31:0] magic_cfg = MAGIC_WORD_RESET;
    logic [12:0] hs_len_cfg = HANDSHAKE_LEN_RESET;
    logic [15:0] max_len_cfg = MAX_MSG_LEN_RESET;

    // connection state of the prediction
    lpd_phase_t  conn_phase = PH_HANDSHAKE;
    logic [11:0] hs_seen = '0;
    logic        magic_match = 1'b1;
    logic [31:0] hdr_bytes_acc = '0;
    logic [2:0]  hdr_seen = '0;
    logic [15:0] body_left = '0;
    logic [15:0] cur_len = '0;

    lpd_in_t     pending_bytes [$];
    lpd_out_t    expected_out [$];
    lpd_out_t    predicted;
    lpd_out_t    want_res;

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned error_count = 0;
    int unsigned settings_count = 0;
    int unsigned msgs_done = 0;
    int unsigned kind_seen [4] = '{default: 0};
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned tx_calm = 0;
    int unsigned rx_calm = 0;
    bit          hold_request = 1'b0;

    length_prefixed_deframer_unit #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned draw_gap(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        case ($urandom_range(0, 19))
            0: begin
                calm = $urandom_range(20, 80);
                return 0;
            end
            1: return $urandom_range(10, 30);
            2, 3, 4, 5: return $urandom_range(1, 3);
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned handshake_span();
        if (hs_len_cfg < HANDSHAKE_LEN_MIN) return HANDSHAKE_LEN_MIN;
        if (hs_len_cfg > HANDSHAKE_LEN_MAX) return HANDSHAKE_LEN_MAX;
        return hs_len_cfg;
    endfunction

    function automatic bit length_ok(input logic [31:0] len);
        return len >= MIN_MSG_LEN && len <= max_len_cfg && len <= LEN_CAP;
    endfunction

    function automatic bit deframe_byte(input lpd_in_t in, output lpd_out_t res);
        logic [31:0] len;
        res.kind = KIND_DATA;
        res.out_byte = 8'h00;
        res.message_last = 1'b0;
        res.message_length = 16'h0000;
        if (in.connection_start) begin
            conn_phase = PH_HANDSHAKE;
            hs_seen = '0;
            magic_match = 1'b1;
            hdr_bytes_acc = '0;
            hdr_seen = '0;
            body_left = '0;
            cur_len = '0;
        end
        if (conn_phase == PH_HANDSHAKE) begin
            if (hs_seen < 4) begin
                if (magic_cfg[8*hs_seen +: 8] != in.data_byte) magic_match = 1'b0;
            end
            if (int'(hs_seen) + 1 >= handshake_span()) begin
                hs_seen = '0;
                if (magic_match) begin
                    conn_phase = PH_STREAM;
                    res.kind = KIND_ACCEPT;
                end else begin
                    conn_phase = PH_CLOSED;
                    res.kind = KIND_REJECT;
                end
                return 1'b1;
            end
            hs_seen = hs_seen + 12'd1;
            return 1'b0;
        end
        if (conn_phase != PH_STREAM) return 1'b0;
        res.out_byte = in.data_byte;
        if (hdr_seen < HEADER_BYTES) begin
            hdr_bytes_acc[8*hdr_seen +: 8] = in.data_byte;
            hdr_seen = hdr_seen + 3'd1;
            if (hdr_seen < HEADER_BYTES) return 1'b1;
            len = hdr_bytes_acc;
            if (!length_ok(len)) begin
                conn_phase = PH_CLOSED;
                hdr_seen = '0;
                hdr_bytes_acc = '0;
                res.kind = KIND_BADLEN;
                res.out_byte = 8'h00;
                return 1'b1;
            end
            cur_len = len[15:0];
            res.message_length = len[15:0];
            if (len == MIN_MSG_LEN) begin
                hdr_seen = '0;
                hdr_bytes_acc = '0;
                res.message_last = 1'b1;
                return 1'b1;
            end
            body_left = len[15:0] - 16'd4;
            return 1'b1;
        end
        if (body_left > 0) body_left = body_left - 16'd1;
        res.message_length = cur_len;
        if (body_left == 0) begin
            hdr_seen = '0;
            hdr_bytes_acc = '0;
            cur_len = '0;
            res.message_last = 1'b1;
        end
        return 1'b1;
    endfunction

    // byte sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                bytes_taken++;
                if (deframe_byte(s_data, predicted)) begin
                    expected_out.insert(expected_out.size(), predicted);
                end
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    s_data <= pending_bytes.pop_front();
                    s_valid <= 1'b1;
                    gap_left = draw_gap(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_out.size() == 0) begin
                    $error("unexpected transaction: kind %0d byte %h length %0d",
                           m_data.kind, m_data.out_byte, m_data.message_length);
                    error_count++;
                end else begin
                    want_res = expected_out.pop_front();
                    if (m_data.kind !== want_res.kind) begin
                        $error("kind: expected %0d, got %0d", want_res.kind, m_data.kind);
                        error_count++;
                    end
                    if (m_data.out_byte !== want_res.out_byte) begin
                        $error("out_byte: expected %h, got %h",
                               want_res.out_byte, m_data.out_byte);
                        error_count++;
                    end
                    if (m_data.message_last !== want_res.message_last) begin
                        $error("message_last: expected %0d, got %0d",
                               want_res.message_last, m_data.message_last);
                        error_count++;
                    end
                    if (m_data.message_length !== want_res.message_length) begin
                        $error("message_length: expected %0d, got %0d",
                               want_res.message_length, m_data.message_length);
                        error_count++;
                    end
                    kind_seen[want_res.kind]++;
                    if (want_res.message_last) msgs_done++;
                end
                stall_left = draw_gap(rx_calm);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit start);
        lpd_in_t item;
        item.data_byte = b;
        item.connection_start = start;
        pending_bytes.insert(pending_bytes.size(), item);
        bytes_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_bytes.size() != 0 || s_valid || expected_out.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_MAGIC_WORD:    magic_cfg = value;
            CFG_HANDSHAKE_LEN: hs_len_cfg = value[12:0];
            CFG_MAX_MSG_LEN:   max_len_cfg = value[15:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] magic, input logic [12:0] hs,
                             input logic [15:0] maxl);
        wait_idle();
        write_reg(CFG_MAGIC_WORD, magic);
        write_reg(CFG_HANDSHAKE_LEN, {19'd0, hs});
        write_reg(CFG_MAX_MSG_LEN, {16'd0, maxl});
        settings_count++;
    endtask

    task automatic open_connection(input bit good);
        int unsigned span;
        int unsigned bad_pos;
        logic [7:0] b;
        span = handshake_span();
        bad_pos = $urandom_range(0, 3);
        for (int unsigned i = 0; i < span; i++) begin
            if (i < 4) b = magic_cfg[8*i +: 8];
            else b = $urandom_range(0, 255);
            if (!good && i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
            send_byte(b, i == 0);
        end
    endtask

    task automatic send_message(input logic [31:0] len, input int keep);
        int total;
        total = length_ok(len) ? int'(len) : 4;
        if (keep >= 0 && keep < total) total = keep;
        for (int i = 0; i < total; i++) begin
            if (i < 4) send_byte(len[8*i +: 8], 1'b0);
            else send_byte($urandom_range(0, 255), 1'b0);
        end
    endtask

    function automatic logic [31:0] choose_length();
        int unsigned top;
        top = (max_len_cfg < 40) ? max_len_cfg : 40;
        case ($urandom_range(0, 19))
            0: return $urandom_range(0, 3);
            1: begin
                if (max_len_cfg == 16'hFFFF) return 32'h10000 + $urandom_range(0, 255);
                return max_len_cfg + $urandom_range(1, 20);
            end
            2: return $urandom;
            3: begin
                if (max_len_cfg < 4) return $urandom_range(0, 3);
                return $urandom_range(4, (max_len_cfg < 300) ? max_len_cfg : 300);
            end
            default: begin
                if (top < 4) return $urandom_range(0, 3);
                return $urandom_range(4, top);
            end
        endcase
    endfunction

    initial begin
        logic [31:0] magic;
        logic [31:0] len;
        logic [12:0] hs;
        logic [15:0] maxl;
        int unsigned random_items;
        int unsigned phase_start;
        int unsigned queued_mark;
        int unsigned n;
        int pick;
        bit good;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset defaults of magic word and length limit, short handshake
        write_reg(CFG_HANDSHAKE_LEN, 32'd4);
        open_connection(1'b1);
        send_message(32'd6, WHOLE);
        open_connection(1'b1);
        send_message(32'h0001_0000, WHOLE);

        magic = $urandom;
        configure(magic, 13'd4, 16'hFFFF);
        open_connection(1'b1);
        send_message(32'd4, WHOLE);
        send_message(32'd5, WHOLE);
        send_message(32'd3, WHOLE);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        open_connection(1'b0);
        send_byte(8'hA5, 1'b0);
        open_connection(1'b1);
        send_message(32'hFFFF_FFFF, WHOLE);
        open_connection(1'b1);
        send_message(32'h0001_0000, WHOLE);
        open_connection(1'b1);
        send_message(32'd0, WHOLE);
        open_connection(1'b1);
        send_message(32'd9, 6);
        send_byte(magic[7:0], 1'b1);
        send_byte(magic[15:8], 1'b0);
        open_connection(1'b1);
        send_message(32'd20, 2);
        open_connection(1'b1);
        send_message(32'd6, WHOLE);

        // register writes mid-stream keep the connection state
        configure(magic, 13'd0, 16'd7);
        write_reg(CFG_UNUSED, $urandom);
        send_message(32'd7, WHOLE);
        send_message(32'd8, WHOLE);
        open_connection(1'b1);
        send_message(32'd7, WHOLE);

        configure(32'hFFFF_FFFF, 13'd3, 16'd3);
        open_connection(1'b1);
        send_message(32'd4, WHOLE);
        configure(32'hFFFF_FFFF, 13'd5, 16'd0);
        open_connection(1'b1);
        send_message(32'd4, WHOLE);

        configure($urandom, 13'd6, 16'd4);
        open_connection(1'b1);
        send_message(32'd4, WHOLE);
        send_message(32'd5, WHOLE);
        configure(32'h0000_0000, 13'd4, 16'hFFFF);
        open_connection(1'b1);
        send_message(32'd40, WHOLE);
        send_message(32'd4, WHOLE);

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            magic = ($urandom_range(0, 1) == 0) ? MAGIC_WORD_RESET : $urandom;
            case ($urandom_range(0, 9))
                0: hs = $urandom_range(0, 3);
                1: hs = $urandom_range(9, 40);
                default: hs = $urandom_range(4, 8);
            endcase
            case ($urandom_range(0, 9))
                0: maxl = $urandom_range(0, 3);
                1, 2, 3: maxl = $urandom_range(4, 12);
                4, 5: maxl = $urandom_range(13, 64);
                6, 7: maxl = 16'hFFFF;
                default: maxl = $urandom_range(4, 65535);
            endcase
            configure(magic, hs, maxl);
            if (random_items == 0 || $urandom_range(0, 2) == 0) hold_request = 1'b1;
            phase_start = random_items;
            while (random_items - phase_start < 150) begin
                pick = (random_items == phase_start) ? 9 : $urandom_range(0, 9);
                queued_mark = bytes_queued;
                case (pick)
                    0: begin
                        n = $urandom_range(3, 20);
                        repeat (n) send_byte($urandom_range(0, 255), $urandom_range(0, 7) == 0);
                    end
                    1: begin
                        open_connection(1'b1);
                        send_message($urandom_range(5, 40), $urandom_range(1, 8));
                    end
                    default: begin
                        good = $urandom_range(0, 9) != 0;
                        open_connection(good);
                        if (good) begin
                            n = $urandom_range(1, 5);
                            for (int i = 0; i < n; i++) begin
                                len = choose_length();
                                send_message(len, WHOLE);
                                if (!length_ok(len)) break;
                            end
                        end
                    end
                endcase
                random_items += bytes_queued - queued_mark;
            end
        end

        wait_idle();
        $display("%0d bytes taken, %0d result transactions checked over %0d register settings",
                 bytes_taken, kind_seen[0] + kind_seen[1] + kind_seen[2] + kind_seen[3],
                 settings_count);
        $display("handshakes accepted %0d, rejected %0d; messages completed %0d, bad lengths %0d",
                 kind_seen[KIND_ACCEPT], kind_seen[KIND_REJECT], msgs_done,
                 kind_seen[KIND_BADLEN]);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("timeout: deframer stopped making progress");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
